[sv/slmf_pkg.sv]
// ----------------------------------------------------------------------------
// slmf_pkg
// shared types and constants of the serpentine led matrix frame store
// ----------------------------------------------------------------------------
package slmf_pkg;

  localparam int OP_W     = 2;
  localparam int COORD_W  = 8;
  localparam int PIX_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int MAX_IDX_W = 14;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam int START_BYTES = 4;
  localparam int END_BYTES   = 4;
  localparam int LEDS_PER_TAIL_WORD = 32;

  localparam logic [BYTE_W-1:0] LED_HDR_BYTE = 8'hE0;
  localparam logic [BYTE_W-1:0] END_BYTE     = 8'hFF;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_WRITE,
    CMD_READ,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic                   hit;
    logic                   eor;
    logic [MAX_IDX_W-1:0]   idx;
    logic [PIX_W-1:0]       pixel;
  } cmd_t;

  typedef enum logic [2:0] {
    BYTE_ZERO,
    BYTE_HDR,
    BYTE_BLUE,
    BYTE_GREEN,
    BYTE_RED,
    BYTE_END
  } byte_sel_t;

  typedef struct packed {
    logic       serial_valid;
    byte_sel_t  sel;
    logic       frame_done;
    logic       read_valid;
    logic       read_error;
  } res_meta_t;

endpackage

[sv/slmf_if.sv]
// ----------------------------------------------------------------------------
// slmf_in_if / slmf_out_if
// valid/ready channels for pixel commands and per-command results
// ----------------------------------------------------------------------------
interface slmf_in_if;
  import slmf_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] column;
  logic [PIX_W-1:0]   pixel;
  logic               end_of_run;

  modport source (output valid, op, row, column, pixel, end_of_run, input ready);
  modport sink   (input valid, op, row, column, pixel, end_of_run, output ready);
endinterface

interface slmf_out_if;
  import slmf_pkg::*;

  logic              valid;
  logic              ready;
  logic              serial_valid;
  logic [BYTE_W-1:0] serial_byte;
  logic              frame_done;
  logic              read_valid;
  logic [PIX_W-1:0]  read_pixel;
  logic              read_error;

  modport source (output valid, serial_valid, serial_byte, frame_done, read_valid,
                  read_pixel, read_error, input ready);
  modport sink   (input valid, serial_valid, serial_byte, frame_done, read_valid,
                  read_pixel, read_error, output ready);
endinterface

[sv/slmf_queue.sv]
// ----------------------------------------------------------------------------
// slmf_queue
// two-entry command queue between the front and the back
// ----------------------------------------------------------------------------
module slmf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  slmf_pkg::cmd_t push_cmd,
  input  logic           pop,
  output slmf_pkg::cmd_t pop_cmd,
  output logic           full,
  output logic           empty
);
  import slmf_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[sv/slmf_front.sv]
// ----------------------------------------------------------------------------
// slmf_front
// accepts input words, range-checks them and maps row/column to chain index
// ----------------------------------------------------------------------------
module slmf_front #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 16
) (
  slmf_in_if.sink        in_chan,
  input  logic           queue_full,
  input  logic           clear_busy,
  output logic           push,
  output slmf_pkg::cmd_t push_cmd
);
  import slmf_pkg::*;

  logic                 row_ok;
  logic                 col_ok;
  logic [COORD_W-1:0]   col_eff;
  logic [MAX_IDX_W-1:0] row_base;

  assign in_chan.ready = !queue_full && !clear_busy;
  assign push          = in_chan.valid && in_chan.ready;

  always_comb begin
    row_ok   = ({1'b0, in_chan.row} < (COORD_W + 1)'(ROWS));
    col_ok   = ({1'b0, in_chan.column} < (COORD_W + 1)'(COLUMNS));
    col_eff  = in_chan.row[0] ? (COORD_W'(COLUMNS - 1) - in_chan.column) : in_chan.column;
    row_base = MAX_IDX_W'(in_chan.row) * MAX_IDX_W'(COLUMNS);

    push_cmd.hit   = row_ok && col_ok;
    push_cmd.eor   = in_chan.end_of_run;
    push_cmd.idx   = row_base + MAX_IDX_W'(col_eff);
    push_cmd.pixel = in_chan.pixel;
    case (in_chan.op)
      OP_WRITE: push_cmd.kind = CMD_WRITE;
      OP_READ:  push_cmd.kind = CMD_READ;
      OP_TICK:  push_cmd.kind = CMD_TICK;
      default:  push_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

[sv/slmf_back.sv]
// ----------------------------------------------------------------------------
// slmf_back
// frame memory, refresh stream sequencer and result output register
// ----------------------------------------------------------------------------
module slmf_back #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  slmf_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           clear_busy,
  slmf_out_if.source     out_chan
);
  import slmf_pkg::*;

  localparam int N        = COLUMNS * ROWS;
  localparam int IDX_W    = (N > 1) ? $clog2(N) : 1;
  localparam int LED_END  = START_BYTES + 4 * N;
  localparam int END_END  = LED_END + END_BYTES;
  localparam int LEN      = END_END + 4 * (1 + N / LEDS_PER_TAIL_WORD);
  localparam int POS_W    = $clog2(LEN);

  logic [PIX_W-1:0]  frame_mem_r [N];
  logic [PIX_W-1:0]  rd_data_r;

  logic              clearing_r;
  logic [IDX_W-1:0]  clr_cnt_r;

  logic              active_r;
  logic              active_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic [POS_W:0]    pos_inc;
  logic [POS_W-3:0]  led_k;

  logic              s1_v_r;
  logic              s1_v_nxt;
  res_meta_t         s1_meta_r;
  res_meta_t         s1_meta_nxt;
  logic              s1_adv;

  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;

  logic              out_v_r;
  logic              serial_valid_r;
  logic [BYTE_W-1:0] serial_byte_r;
  logic              frame_done_r;
  logic              read_valid_r;
  logic [PIX_W-1:0]  read_pixel_r;
  logic              read_error_r;
  logic [BYTE_W-1:0] byte_nxt;

  assign clear_busy = clearing_r;
  assign s1_adv     = s1_v_r && (!out_v_r || out_chan.ready);
  assign pop        = !q_empty && !clearing_r && (!s1_v_r || s1_adv);
  assign led_k      = pos_r[POS_W-1:2] - (POS_W - 2)'(1);
  assign pos_inc    = {1'b0, pos_r} + (POS_W + 1)'(1);

  always_comb begin
    active_nxt  = active_r;
    pos_nxt     = pos_r;
    s1_meta_nxt = '0;
    rd_addr     = q_cmd.idx[IDX_W-1:0];
    wr_en       = 1'b0;
    if (pop) begin
      case (q_cmd.kind)
        CMD_WRITE: begin
          wr_en = q_cmd.hit;
          if (q_cmd.eor) begin
            active_nxt = 1'b1;
            pos_nxt    = '0;
          end
        end
        CMD_READ: begin
          s1_meta_nxt.read_valid = q_cmd.hit;
          s1_meta_nxt.read_error = !q_cmd.hit;
        end
        CMD_TICK: begin
          rd_addr = IDX_W'(led_k);
          if (active_r) begin
            s1_meta_nxt.serial_valid = 1'b1;
            if (pos_r < POS_W'(START_BYTES)) begin
              s1_meta_nxt.sel = BYTE_ZERO;
            end else if (pos_r < POS_W'(LED_END)) begin
              case (pos_r[1:0])
                2'd0:    s1_meta_nxt.sel = BYTE_HDR;
                2'd1:    s1_meta_nxt.sel = BYTE_BLUE;
                2'd2:    s1_meta_nxt.sel = BYTE_GREEN;
                default: s1_meta_nxt.sel = BYTE_RED;
              endcase
            end else if (pos_r < POS_W'(END_END)) begin
              s1_meta_nxt.sel = BYTE_END;
            end else begin
              s1_meta_nxt.sel = BYTE_ZERO;
            end
            if (pos_inc == (POS_W + 1)'(LEN)) begin
              s1_meta_nxt.frame_done = 1'b1;
              active_nxt             = 1'b0;
              pos_nxt                = '0;
            end else begin
              pos_nxt = pos_inc[POS_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (pop) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_comb begin
    case (s1_meta_r.sel)
      BYTE_HDR:   byte_nxt = LED_HDR_BYTE;
      BYTE_BLUE:  byte_nxt = {rd_data_r[4:0], 3'b000};
      BYTE_GREEN: byte_nxt = {rd_data_r[10:5], 2'b00};
      BYTE_RED:   byte_nxt = {rd_data_r[15:11], 3'b000};
      BYTE_END:   byte_nxt = END_BYTE;
      default:    byte_nxt = '0;
    endcase
  end

  // frame memory: clearing sweep after reset, then one write and one read port
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      frame_mem_r[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      frame_mem_r[q_cmd.idx[IDX_W-1:0]] <= q_cmd.pixel;
    end
    if (pop) begin
      rd_data_r <= frame_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      active_r   <= 1'b1;
      pos_r      <= '0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(N - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      s1_v_r   <= s1_v_nxt;
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_meta_r <= s1_meta_nxt;
    end
    if (s1_adv) begin
      serial_valid_r <= s1_meta_r.serial_valid;
      serial_byte_r  <= s1_meta_r.serial_valid ? byte_nxt : '0;
      frame_done_r   <= s1_meta_r.frame_done;
      read_valid_r   <= s1_meta_r.read_valid;
      read_pixel_r   <= s1_meta_r.read_valid ? rd_data_r : '0;
      read_error_r   <= s1_meta_r.read_error;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.serial_valid = serial_valid_r;
  assign out_chan.serial_byte  = serial_byte_r;
  assign out_chan.frame_done   = frame_done_r;
  assign out_chan.read_valid   = read_valid_r;
  assign out_chan.read_pixel   = read_pixel_r;
  assign out_chan.read_error   = read_error_r;

endmodule

[sv/serpentine_led_matrix_framebuffer.sv]
// ----------------------------------------------------------------------------
// serpentine_led_matrix_framebuffer
// frame store and refresh byte stream for a serpentine chain of serial rgb leds
// ----------------------------------------------------------------------------
// Every input word (pixel write, pixel read or stream tick) returns exactly
// one result word, in order. After reset the block clears the frame memory,
// one entry per clock, during which in_chan.ready stays low. After that it
// sustains one word per clock when the output is not stalled: the front maps
// row/column to the chain index and pushes a command into a two-entry queue,
// the back executes it against the frame memory (one write port and one read
// port), registering the read data and the result metadata, and the result
// leaves through an output register.
// ----------------------------------------------------------------------------
module serpentine_led_matrix_framebuffer #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  slmf_in_if.sink     in_chan,
  slmf_out_if.source  out_chan
);
  import slmf_pkg::*;

  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  cmd_t q_pop_cmd;
  logic q_full;
  logic q_empty;
  logic clear_busy;

  slmf_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_chan    (in_chan),
    .queue_full (q_full),
    .clear_busy (clear_busy),
    .push       (q_push),
    .push_cmd   (q_push_cmd)
  );

  slmf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  slmf_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (q_pop_cmd),
    .pop        (q_pop),
    .clear_busy (clear_busy),
    .out_chan   (out_chan)
  );

endmodule
